/* rtl/core/aps_pkg.sv */
// Shared types, codes and constants for the ATA PIO sector transfer sequencer.
package aps_pkg;

	// Sequencer phase
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_POLL,
		PH_DATA
	} phase_t;

	// Input item kinds
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_STATUS = 2'd1;
	localparam logic [1:0] KIND_DATA   = 2'd2;

	// Result operations
	localparam logic [1:0] OP_REG_WR  = 2'd0;
	localparam logic [1:0] OP_STAT_RD = 2'd1;
	localparam logic [1:0] OP_DATA    = 2'd2;
	localparam logic [1:0] OP_DONE    = 2'd3;

	// Completion codes
	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_ERR     = 2'd1;
	localparam logic [1:0] RES_DF      = 2'd2;
	localparam logic [1:0] RES_TIMEOUT = 2'd3;

	// Task-file register offsets
	localparam logic [2:0] REG_NONE    = 3'd0;
	localparam logic [2:0] REG_COUNT   = 3'd2;
	localparam logic [2:0] REG_LBA_LO  = 3'd3;
	localparam logic [2:0] REG_LBA_MID = 3'd4;
	localparam logic [2:0] REG_LBA_HI  = 3'd5;
	localparam logic [2:0] REG_HEAD    = 3'd6;
	localparam logic [2:0] REG_CMD     = 3'd7;

	// Command bytes
	localparam logic [7:0] HEAD_BASE = 8'hE0;
	localparam logic [7:0] CMD_READ  = 8'h20;
	localparam logic [7:0] CMD_WRITE = 8'h30;
	localparam logic [7:0] CMD_FLUSH = 8'hE7;

	// Status bit positions
	localparam int ST_BSY = 7;
	localparam int ST_DF  = 5;
	localparam int ST_DRQ = 3;
	localparam int ST_ERR = 0;

	localparam logic [23:0] POLL_LIMIT_RESET = 24'd100000;
	localparam int          WORDS_PER_SECTOR = 256;
	localparam logic [7:0]  WORD_LAST        = 8'(WORDS_PER_SECTOR - 1);
	localparam logic [8:0]  MAX_SECTORS      = 9'd256;

	// Result slots of one burst, emitted lowest first
	localparam int ENT_HEAD  = 0;
	localparam int ENT_LO    = 1;
	localparam int ENT_MID   = 2;
	localparam int ENT_HI    = 3;
	localparam int ENT_COUNT = 4;
	localparam int ENT_CMD   = 5;
	localparam int ENT_DATA  = 6;
	localparam int ENT_FLUSH = 7;
	localparam int ENT_TAIL  = 8;
	localparam int NUM_ENT   = 9;
	localparam int ENT_W     = $clog2(NUM_ENT);

	// Burst of results caused by one input item
	typedef struct packed {
		logic [NUM_ENT-1:0] mask;
		logic               chan;
		logic               drive;
		logic [27:0]        lba;
		logic [7:0]         cnt;
		logic               wr;
		logic [15:0]        word;
		logic [15:0]        idx;
		logic               tail_done;
		logic [1:0]         code;
	} desc_t;

	// One result word
	typedef struct packed {
		logic [1:0]  op;
		logic        chan;
		logic [2:0]  off;
		logic [7:0]  val;
		logic [15:0] word;
		logic [15:0] idx;
		logic [1:0]  code;
		logic        last;
	} rsp_t;

endpackage

/* rtl/core/ata_pio_sector_transfer.sv */
// An accepted word passes through the input register, the burst holder and the output
// register before its first result shows.
// Throughput: one input word per cycle while rsp_stall is low and each causes at most one
// result. The output moves one result per cycle unless stalled; a start word makes seven.
// The input accepts while results of the previous word still drain from the burst holder.
// Reset (arst_n low, asynchronous): idle phase, poll_limit 100000, no pending results.
module ata_pio_sector_transfer
	import aps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  kind,
	input  logic        drive,
	input  logic        channel,
	input  logic [27:0] lba,
	input  logic [7:0]  sec_count,
	input  logic        is_write,
	input  logic [7:0]  status,
	input  logic [15:0] data_word,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  op,
	output logic        bus_channel,
	output logic [2:0]  reg_offset,
	output logic [7:0]  reg_value,
	output logic [15:0] word,
	output logic [15:0] word_index,
	output logic [1:0]  result_code,
	output logic        last,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata
);

	desc_t desc;
	logic  desc_vld;
	logic  desc_free;
	rsp_t  rsp;

	// item decode and transfer state
	aps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.kind         (kind),
		.drive        (drive),
		.channel      (channel),
		.lba          (lba),
		.sec_count    (sec_count),
		.is_write     (is_write),
		.status       (status),
		.data_word    (data_word),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.desc         (desc),
		.desc_vld     (desc_vld),
		.desc_free    (desc_free)
	);

	// result sequencing and output register
	aps_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.desc      (desc),
		.desc_vld  (desc_vld),
		.desc_free (desc_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign op          = rsp.op;
	assign bus_channel = rsp.chan;
	assign reg_offset  = rsp.off;
	assign reg_value   = rsp.val;
	assign word        = rsp.word;
	assign word_index  = rsp.idx;
	assign result_code = rsp.code;
	assign last        = rsp.last;

endmodule

/* rtl/core/aps_ctrl.sv */
// Input register, transfer state and per-item decode into a result burst.
module aps_ctrl
	import aps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  kind,
	input  logic        drive,
	input  logic        channel,
	input  logic [27:0] lba,
	input  logic [7:0]  sec_count,
	input  logic        is_write,
	input  logic [7:0]  status,
	input  logic [15:0] data_word,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	output desc_t       desc,
	output logic        desc_vld,
	input  logic        desc_free
);

	// input stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic        drive_s1;
	logic        channel_s1;
	logic [27:0] lba_s1;
	logic [7:0]  cnt_s1;
	logic        wr_s1;
	logic [7:0]  status_s1;
	logic [15:0] word_s1;

	// transfer state
	logic [23:0] poll_limit_q;
	phase_t      phase_q, phase_d;
	logic [23:0] cd_q, cd_d, cd_dec;
	logic [8:0]  sl_q, sl_d, sl_dec;
	logic [7:0]  sn_q, sn_d;
	logic [7:0]  wis_q, wis_d;
	logic        wm_q, wm_d;
	logic        ch_q, ch_d;
	logic        wdrq_q, wdrq_d;

	logic        consume, accept;
	logic [8:0]  n_sec;
	logic        retry, poll_go, poll_drq, fin, stat_req;
	logic [1:0]  fin_code;
	desc_t       desc_d;

	assign consume   = valid_s1 && ((desc_d.mask == '0) || desc_free);
	assign cmd_stall = valid_s1 && !consume;
	assign accept    = cmd_valid && !cmd_stall;
	assign desc      = desc_d;
	assign desc_vld  = consume && (desc_d.mask != '0);

	// sector count, zero meaning the full 256
	always_comb begin
		n_sec = (cnt_s1 == 8'd0) ? 9'd256 : {1'b0, cnt_s1};
		if (n_sec > MAX_SECTORS) begin
			n_sec = MAX_SECTORS;
		end
	end

	assign cd_dec = (cd_q != 24'd0) ? cd_q - 24'd1 : cd_q;
	assign sl_dec = (sl_q != 9'd0) ? sl_q - 9'd1 : sl_q;

	// decode of the item in the input stage
	always_comb begin
		phase_d  = phase_q;
		cd_d     = cd_q;
		sl_d     = sl_q;
		sn_d     = sn_q;
		wis_d    = wis_q;
		wm_d     = wm_q;
		ch_d     = ch_q;
		wdrq_d   = wdrq_q;
		desc_d   = '0;
		retry    = 1'b0;
		poll_go  = 1'b0;
		poll_drq = 1'b0;
		fin      = 1'b0;
		fin_code = RES_OK;
		stat_req = 1'b0;
		if (valid_s1) begin
			case (kind_s1)
				KIND_START: begin
					if (phase_q == PH_IDLE) begin
						ch_d  = channel_s1;
						wm_d  = wr_s1;
						sl_d  = n_sec;
						sn_d  = 8'd0;
						wis_d = 8'd0;
						desc_d.mask[ENT_CMD:ENT_HEAD] = '1;
						poll_go  = 1'b1;
						poll_drq = 1'b1;
					end
				end
				KIND_STATUS: begin
					if (phase_q == PH_POLL) begin
						if (status_s1[ST_BSY]) begin
							retry = 1'b1;
						end else if (status_s1[ST_ERR]) begin
							fin      = 1'b1;
							fin_code = RES_ERR;
						end else if (status_s1[ST_DF]) begin
							fin      = 1'b1;
							fin_code = RES_DF;
						end else if (!wdrq_q) begin
							fin      = 1'b1;
							fin_code = RES_OK;
						end else if (status_s1[ST_DRQ]) begin
							phase_d = PH_DATA;
							wis_d   = 8'd0;
						end else begin
							retry = 1'b1;
						end
					end
				end
				KIND_DATA: begin
					if (phase_q == PH_DATA) begin
						desc_d.mask[ENT_DATA] = 1'b1;
						if (wis_q == WORD_LAST) begin
							wis_d = 8'd0;
							sn_d  = sn_q + 8'd1;
							sl_d  = sl_dec;
							if (sl_dec != 9'd0) begin
								poll_go  = 1'b1;
								poll_drq = 1'b1;
							end else if (wm_q) begin
								desc_d.mask[ENT_FLUSH] = 1'b1;
								poll_go  = 1'b1;
								poll_drq = 1'b0;
							end else begin
								fin      = 1'b1;
								fin_code = RES_OK;
							end
						end else begin
							wis_d = wis_q + 8'd1;
						end
					end
				end
				default: ;
			endcase
		end
		// busy or missing DRQ: count down and poll again until timeout
		if (retry) begin
			cd_d = cd_dec;
			if (cd_dec <= 24'd1) begin
				fin      = 1'b1;
				fin_code = RES_TIMEOUT;
			end else begin
				stat_req = 1'b1;
			end
		end
		// new poll: reload the countdown; a limit of 1 or less times out
		if (poll_go) begin
			wdrq_d = poll_drq;
			cd_d   = poll_limit_q;
			if (poll_limit_q <= 24'd1) begin
				fin      = 1'b1;
				fin_code = RES_TIMEOUT;
			end else begin
				stat_req = 1'b1;
			end
		end
		if (fin) begin
			phase_d               = PH_IDLE;
			desc_d.mask[ENT_TAIL] = 1'b1;
			desc_d.tail_done      = 1'b1;
			desc_d.code           = fin_code;
		end
		if (stat_req) begin
			phase_d               = PH_POLL;
			desc_d.mask[ENT_TAIL] = 1'b1;
		end
		desc_d.chan  = ch_d;
		desc_d.drive = drive_s1;
		desc_d.lba   = lba_s1;
		desc_d.cnt   = cnt_s1;
		desc_d.wr    = wr_s1;
		desc_d.word  = word_s1;
		desc_d.idx   = {sn_q, wis_q};
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1    <= kind;
			drive_s1   <= drive;
			channel_s1 <= channel;
			lba_s1     <= lba;
			cnt_s1     <= sec_count;
			wr_s1      <= is_write;
			status_s1  <= status;
			word_s1    <= data_word;
		end
	end

	// poll limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q <= POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			poll_limit_q <= cfg_wdata;
		end
	end

	// transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cd_q    <= '0;
			sl_q    <= '0;
			sn_q    <= '0;
			wis_q   <= '0;
			wm_q    <= 1'b0;
			ch_q    <= 1'b0;
			wdrq_q  <= 1'b1;
		end else if (consume) begin
			phase_q <= phase_d;
			cd_q    <= cd_d;
			sl_q    <= sl_d;
			sn_q    <= sn_d;
			wis_q   <= wis_d;
			wm_q    <= wm_d;
			ch_q    <= ch_d;
			wdrq_q  <= wdrq_d;
		end
	end

	// a data phase always has a sector outstanding
	a_data_has_sector: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> sl_q != 9'd0)
		else $error("data phase with no sectors left");

	// a burst is handed over only when the item leaves the input stage
	a_burst_on_consume: assert property (@(posedge clk) disable iff (!arst_n)
		desc_vld |-> consume && desc_free)
		else $error("burst handed over without room");

	// a start item resets the word position
	a_start_clears_word: assert property (@(posedge clk) disable iff (!arst_n)
		consume && kind_s1 == KIND_START && phase_q == PH_IDLE |=>
		wis_q == 8'd0 && phase_q != PH_DATA)
		else $error("start did not clear word position");

endmodule

/* rtl/core/aps_emit.sv */
// Burst holder emitting one result word per cycle into the output register unless stalled.
module aps_emit
	import aps_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  desc_t desc,
	input  logic  desc_vld,
	output logic  desc_free,
	output logic  rsp_valid,
	input  logic  rsp_stall,
	output rsp_t  rsp
);

	desc_t              desc_q;
	logic [NUM_ENT-1:0] mask_q, pick, rem;
	logic [ENT_W-1:0]   sel;
	logic               out_ld;
	logic               rsp_valid_q;
	rsp_t               rsp_q, rsp_d;

	assign out_ld    = !rsp_valid_q || !rsp_stall;
	assign pick      = mask_q & (~mask_q + NUM_ENT'(1));
	assign rem       = mask_q & (mask_q - NUM_ENT'(1));
	assign desc_free = (mask_q == '0) || (out_ld && rem == '0);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// index of the lowest pending slot
	always_comb begin
		sel = '0;
		for (int i = 0; i < NUM_ENT; i++) begin
			if (pick[i]) begin
				sel = ENT_W'(i);
			end
		end
	end

	// build the result word for the selected slot
	always_comb begin
		rsp_d      = '0;
		rsp_d.chan = desc_q.chan;
		rsp_d.last = (rem == '0);
		case (sel)
			ENT_W'(ENT_HEAD): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_HEAD;
				rsp_d.val = HEAD_BASE | {3'b000, desc_q.drive, desc_q.lba[27:24]};
			end
			ENT_W'(ENT_LO): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_LBA_LO;
				rsp_d.val = desc_q.lba[7:0];
			end
			ENT_W'(ENT_MID): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_LBA_MID;
				rsp_d.val = desc_q.lba[15:8];
			end
			ENT_W'(ENT_HI): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_LBA_HI;
				rsp_d.val = desc_q.lba[23:16];
			end
			ENT_W'(ENT_COUNT): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_COUNT;
				rsp_d.val = desc_q.cnt;
			end
			ENT_W'(ENT_CMD): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_CMD;
				rsp_d.val = desc_q.wr ? CMD_WRITE : CMD_READ;
			end
			ENT_W'(ENT_DATA): begin
				rsp_d.op   = OP_DATA;
				rsp_d.off  = REG_NONE;
				rsp_d.word = desc_q.word;
				rsp_d.idx  = desc_q.idx;
			end
			ENT_W'(ENT_FLUSH): begin
				rsp_d.op  = OP_REG_WR;
				rsp_d.off = REG_CMD;
				rsp_d.val = CMD_FLUSH;
			end
			ENT_W'(ENT_TAIL): begin
				if (desc_q.tail_done) begin
					rsp_d.op   = OP_DONE;
					rsp_d.off  = REG_NONE;
					rsp_d.code = desc_q.code;
				end else begin
					rsp_d.op  = OP_STAT_RD;
					rsp_d.off = REG_CMD;
				end
			end
			default: ;
		endcase
	end

	// pending slots of the current burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (desc_vld) begin
			mask_q <= desc.mask;
		end else if (out_ld) begin
			mask_q <= rem;
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (desc_vld) begin
			desc_q <= desc;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= (mask_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			rsp_q <= rsp_d;
		end
	end

	// a done word always closes its burst
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.op == OP_DONE |-> rsp_q.last)
		else $error("done word not marked last");

	// a new burst never overwrites pending slots
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		desc_vld |-> desc_free)
		else $error("burst loaded over pending slots");

	// a pending slot moved out shows up as a valid word
	a_slot_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld && mask_q != '0 |=> rsp_valid_q)
		else $error("pending slot lost");

endmodule
